// File: rtl/core/resistor_ladder_key_decoder_assert.svh
// assertion macros of the keypad decoder rtl, used by the debounce stage
`ifndef RESISTOR_LADDER_KEY_DECODER_ASSERT_SVH
`define RESISTOR_LADDER_KEY_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RLKD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rlkd assertion failed");

// next-cycle implication, checked out of reset
`define RLKD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rlkd assertion failed");

`endif

// File: rtl/core/rlkd_pkg.sv
// types and constants of the resistor ladder keypad decoder
`timescale 1ns / 1ps
`default_nettype none

package rlkd_pkg;

  // widths of the threshold, center and hysteresis registers, the stable count and the index
  localparam int CFG_W = 12;
  localparam int SS_W  = 4;
  localparam int IDX_W = 3;

  // classification codes
  localparam logic [1:0] KEY_IDLE   = 2'd0;
  localparam logic [1:0] KEY_PREV   = 2'd1;
  localparam logic [1:0] KEY_TOGGLE = 2'd2;
  localparam logic [1:0] KEY_NEXT   = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IDLE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_PREV    = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOGGLE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEXT    = 3'd4;
  localparam logic [IDX_W-1:0] REG_HYST    = 3'd5;
  localparam logic [IDX_W-1:0] REG_STABLE  = 3'd6;

  // reset values before trimming to the sample width
  localparam int IDLE_THR_DEF = 3000;
  localparam int PREV_DEF     = 975;
  localparam int TOGGLE_DEF   = 1775;
  localparam int NEXT_DEF     = 2350;
  localparam int HYST_DEF     = 80;
  localparam int STABLE_DEF   = 3;

  // configuration as seen by the datapath
  typedef struct packed {
    logic             enable;
    logic [CFG_W-1:0] idle_threshold;
    logic [CFG_W-1:0] center_prev;
    logic [CFG_W-1:0] center_toggle;
    logic [CFG_W-1:0] center_next;
    logic [CFG_W-1:0] hysteresis;
    logic [SS_W-1:0]  stable_samples;
  } rlkd_cfg_t;

  // one key event
  typedef struct packed {
    logic [1:0] key_id;
    logic       pressed;
    logic       last_event;
  } rlkd_event_t;

endpackage

`default_nettype wire

// File: rtl/core/rlkd_cfg.sv
// configuration register file of the keypad decoder
`timescale 1ns / 1ps
`default_nettype none

module rlkd_cfg import rlkd_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  output      rlkd_cfg_t        cfg_o
);

  // reset levels trimmed to the sample width
  localparam int SMASK = (1 << SAMPLE_BITS) - 1;
  localparam logic [CFG_W-1:0] RST_IDLE   = CFG_W'(IDLE_THR_DEF & SMASK);
  localparam logic [CFG_W-1:0] RST_PREV   = CFG_W'(PREV_DEF & SMASK);
  localparam logic [CFG_W-1:0] RST_TOGGLE = CFG_W'(TOGGLE_DEF & SMASK);
  localparam logic [CFG_W-1:0] RST_NEXT   = CFG_W'(NEXT_DEF & SMASK);
  localparam logic [CFG_W-1:0] RST_HYST   = CFG_W'(HYST_DEF & SMASK);
  localparam logic [SS_W-1:0]  RST_SS     = SS_W'(STABLE_DEF);

  rlkd_cfg_t cfg_q, cfg_d;
  logic      wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  // register decode, indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_index_i)
        REG_ENABLE: cfg_d.enable         = cfg_data_i[0];
        REG_IDLE:   cfg_d.idle_threshold = cfg_data_i;
        REG_PREV:   cfg_d.center_prev    = cfg_data_i;
        REG_TOGGLE: cfg_d.center_toggle  = cfg_data_i;
        REG_NEXT:   cfg_d.center_next    = cfg_data_i;
        REG_HYST:   cfg_d.hysteresis     = cfg_data_i;
        REG_STABLE: cfg_d.stable_samples = cfg_data_i[SS_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b1;
      cfg_q.idle_threshold <= RST_IDLE;
      cfg_q.center_prev    <= RST_PREV;
      cfg_q.center_toggle  <= RST_TOGGLE;
      cfg_q.center_next    <= RST_NEXT;
      cfg_q.hysteresis     <= RST_HYST;
      cfg_q.stable_samples <= RST_SS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/rlkd_classify.sv
// nearest-center classifier with idle threshold and hysteresis
`timescale 1ns / 1ps
`default_nettype none

module rlkd_classify import rlkd_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic [SAMPLE_BITS-1:0] raw_i,
  input  wire rlkd_cfg_t              cfg_i,
  input  wire logic [1:0]             cur_i,
  output      logic [1:0]             cand_o
);

  // signed working width, two bits above the widest operand for sign and differences
  localparam int VW = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 2;

  function automatic logic signed [VW-1:0] dist_f(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
    logic signed [VW-1:0] d;
    d = a - b;
    return d[VW-1] ? -d : d;
  endfunction

  function automatic logic signed [VW-1:0] ext_f(input logic [CFG_W-1:0] v);
    return signed'({{(VW-CFG_W){1'b0}}, v});
  endfunction

  logic signed [VW-1:0] raw_s, thr_s, hy_s, thr_lo;
  logic signed [VW-1:0] dp, dt, dn, dcur, ccur;
  logic [1:0]           near;

  assign raw_s  = signed'({{(VW-SAMPLE_BITS){1'b0}}, raw_i});
  assign thr_s  = ext_f(cfg_i.idle_threshold);
  assign hy_s   = ext_f(cfg_i.hysteresis);
  assign thr_lo = thr_s - hy_s;

  // distance to each key center
  assign dp = dist_f(raw_s, ext_f(cfg_i.center_prev));
  assign dt = dist_f(raw_s, ext_f(cfg_i.center_toggle));
  assign dn = dist_f(raw_s, ext_f(cfg_i.center_next));

  // nearest key, ties to prev then toggle
  always_comb begin
    near = KEY_PREV;
    if (dt < dp && dt <= dn) begin
      near = KEY_TOGGLE;
    end else if (dn < dp && dn < dt) begin
      near = KEY_NEXT;
    end
  end

  // center of the key currently held
  always_comb begin
    case (cur_i)
      KEY_PREV:   ccur = ext_f(cfg_i.center_prev);
      KEY_TOGGLE: ccur = ext_f(cfg_i.center_toggle);
      KEY_NEXT:   ccur = ext_f(cfg_i.center_next);
      default:    ccur = thr_s;
    endcase
  end
  assign dcur = dist_f(raw_s, ccur);

  // final class with hysteresis toward the held state
  always_comb begin
    if (raw_s >= thr_s) begin
      cand_o = KEY_IDLE;
    end else if (cur_i == KEY_IDLE) begin
      cand_o = (raw_s >= thr_lo) ? KEY_IDLE : near;
    end else if (near != cur_i && dcur <= hy_s) begin
      cand_o = cur_i;
    end else begin
      cand_o = near;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rlkd_debounce.sv
// debounce state, event generation and two-entry result buffer
`timescale 1ns / 1ps
`default_nettype none

`include "resistor_ladder_key_decoder_assert.svh"

module rlkd_debounce import rlkd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [SS_W-1:0] stable_samples_i,
  input  wire logic            item_valid_i,
  input  wire logic [1:0]      cand_i,
  output      logic            proc_ready_o,
  output      logic [1:0]      stable_key_o,
  output      logic            ev_valid_o,
  input  wire logic            ev_ready_i,
  output      rlkd_event_t     ev_o
);

  logic [1:0]      stable_q, stable_d;
  logic [1:0]      pending_q, pending_d;
  logic [SS_W-1:0] count_q, count_d, count_inc;
  logic [1:0]      cnt_q, cnt_d;
  rlkd_event_t     ev0_q, ev0_d, ev1_q, ev1_d;
  logic            proc, pop, take;
  rlkd_event_t     rel_ev, prs_ev;

  assign pop          = ev_valid_o & ev_ready_i;
  assign proc_ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ev_ready_i);
  assign proc         = item_valid_i & proc_ready_o;

  // repeat counter saturates at the required count
  assign count_inc = (count_q < stable_samples_i) ? count_q + SS_W'(1) : count_q;
  assign take      = (cand_i == pending_q) && !(count_inc < stable_samples_i)
                     && (cand_i != stable_q);

  assign rel_ev = '{key_id: stable_q - 2'd1, pressed: 1'b0,
                    last_event: (cand_i == KEY_IDLE)};
  assign prs_ev = '{key_id: cand_i - 2'd1, pressed: 1'b1, last_event: 1'b1};

  // state update and buffer load
  always_comb begin
    stable_d  = stable_q;
    pending_d = pending_q;
    count_d   = count_q;
    cnt_d     = cnt_q;
    ev0_d     = ev0_q;
    ev1_d     = ev1_q;
    if (pop) begin
      ev0_d = ev1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (proc) begin
      if (cand_i != pending_q) begin
        pending_d = cand_i;
        count_d   = SS_W'(1);
      end else begin
        count_d = count_inc;
        if (take) begin
          stable_d = cand_i;
          if (stable_q == KEY_IDLE) begin
            ev0_d = prs_ev;
            cnt_d = 2'd1;
          end else if (cand_i == KEY_IDLE) begin
            ev0_d = rel_ev;
            cnt_d = 2'd1;
          end else begin
            ev0_d = rel_ev;
            ev1_d = prs_ev;
            cnt_d = 2'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= KEY_IDLE;
      pending_q <= KEY_IDLE;
      count_q   <= '0;
      cnt_q     <= 2'd0;
    end else begin
      stable_q  <= stable_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      cnt_q     <= cnt_d;
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    ev0_q <= ev0_d;
    ev1_q <= ev1_d;
  end

  assign stable_key_o = stable_q;
  assign ev_valid_o   = (cnt_q != 2'd0);
  assign ev_o         = ev0_q;

  // no new item is taken over a full buffer
  `RLKD_ASSERT_IMP(a_no_proc_full, clk_i, rst_ni, proc, cnt_q != 2'd2)
  // buffer never holds more than two events
  `RLKD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  // an accepted change leaves the pending class equal to the stable one
  `RLKD_ASSERT_IMP(a_stable_pending, clk_i, rst_ni, !$stable(stable_q), pending_q == stable_q)
  // a change of stable key always produces at least one event
  `RLKD_ASSERT_NXT(a_change_emits, clk_i, rst_ni, proc && take, ev_valid_o)

endmodule

`default_nettype wire

// File: rtl/core/resistor_ladder_key_decoder.sv
// top level of the resistor ladder keypad decoder
//
//  channel  direction  handshake                      payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata: raw_sample
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata: key_id, pressed; tlast
//  cfg      in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// one sample per clock if not held; events pass the sample reg, then the event buffer
// a change between two keys yields two events and, with the receiver ready,
// holds the input until the first of them is taken
// one waiting event with the receiver stalled also holds the input
// the sample register and the two-entry event buffer part the two sides
// reset returns all configuration registers to their defaults, keys to idle
// while disabled, samples are taken and dropped with no state change
`timescale 1ns / 1ps
`default_nettype none

module resistor_ladder_key_decoder import rlkd_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // sample stream
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // raw_sample
  // event stream
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [7:0]       m_axis_tdata, // key_id[1:0], pressed[2]
  output      logic             m_axis_tlast,
  // configuration writes
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  rlkd_cfg_t              cfg;
  logic                   in_valid_q, in_valid_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   s_acc, proc_ready;
  logic [1:0]             stable_key, cand;
  rlkd_event_t            ev;

  rlkd_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sample register
  assign s_axis_tready = !in_valid_q || proc_ready;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = cfg.enable;
    end else if (proc_ready) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  rlkd_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .raw_i  (sample_q),
    .cfg_i  (cfg),
    .cur_i  (stable_key),
    .cand_o (cand)
  );

  rlkd_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stable_samples_i (cfg.stable_samples),
    .item_valid_i     (in_valid_q),
    .cand_i           (cand),
    .proc_ready_o     (proc_ready),
    .stable_key_o     (stable_key),
    .ev_valid_o       (m_axis_tvalid),
    .ev_ready_i       (m_axis_tready),
    .ev_o             (ev)
  );

  // result packing
  assign m_axis_tdata = {5'd0, ev.pressed, ev.key_id};
  assign m_axis_tlast = ev.last_event;

endmodule

`default_nettype wire
